@@ sv/dcs_pkg.sv @@
// Package for the dock charge sequencer: command and request codes, step
// machine states, status and homing result structs, and the homing step function.
// No dependencies.
package dcs_pkg;

   localparam logic [7:0]  DEFAULT_CATCH_RESET = 8'd2;
   localparam logic [15:0] POWER_HOLD_RESET    = 16'd1000;
   localparam logic [7:0]  CATCH_TARGET_RESET  = 8'd1;
   localparam logic [7:0]  POWER_CATCH_COUNT   = 8'd1;
   localparam logic [15:0] HOLD_TIMER_MAX      = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_DEFAULT_CATCH = 1'b0,
      CSR_POWER_HOLD    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      REQ_TICK          = 3'd0,
      REQ_START_DEFAULT = 3'd1,
      REQ_START_COUNT   = 3'd2,
      REQ_STOP          = 3'd3,
      REQ_POWER_ON      = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ARM_NONE    = 2'd0,
      ARM_HOLD    = 2'd1,
      ARM_ONCE    = 2'd2,
      ARM_RELEASE = 2'd3
   } arm_cmd_type;

   typedef enum logic [1:0] {
      USB_NONE       = 2'd0,
      USB_CONNECT    = 2'd1,
      USB_DISCONNECT = 2'd2
   } usb_cmd_type;

   typedef enum logic [1:0] {
      SW_NONE = 2'd0,
      SW_ON   = 2'd1,
      SW_OFF  = 2'd2
   } sw_cmd_type;

   typedef enum logic [1:0] {
      CLK_NONE  = 2'd0,
      CLK_START = 2'd1,
      CLK_STOP  = 2'd2
   } clk_cmd_type;

   typedef enum logic [2:0] {
      HOME_IDLE       = 3'd0,
      HOME_SWITCH_OFF = 3'd1,
      HOME_UNPLUG     = 3'd2,
      HOME_RELEASE    = 3'd3,
      HOME_DONE       = 3'd4
   } home_step_type;

   typedef enum logic [2:0] {
      CHARGE_IDLE      = 3'd0,
      CHARGE_INIT      = 3'd1,
      CHARGE_CATCH     = 3'd2,
      CHARGE_PLUG      = 3'd3,
      CHARGE_SWITCH_ON = 3'd4,
      CHARGE_REPLUG    = 3'd5,
      CHARGE_COMPLETE  = 3'd6
   } charge_step_type;

   typedef enum logic [2:0] {
      START_IDLE     = 3'd0,
      START_BEGIN    = 3'd1,
      START_HOMING   = 3'd2,
      START_CHARGING = 3'd3,
      START_DONE     = 3'd4
   } start_step_type;

   typedef enum logic [1:0] {
      STOP_IDLE   = 2'd0,
      STOP_BEGIN  = 2'd1,
      STOP_HOMING = 2'd2,
      STOP_DONE   = 2'd3
   } stop_step_type;

   typedef enum logic [2:0] {
      POWER_IDLE       = 3'd0,
      POWER_BEGIN      = 3'd1,
      POWER_WAIT_START = 3'd2,
      POWER_HOLD       = 3'd3,
      POWER_WAIT_STOP  = 3'd4,
      POWER_DONE       = 3'd5
   } power_step_type;

   typedef struct packed {
      logic released;
      logic caught;
      logic plugged;
      logic unplugged;
      logic sw_on;
   } status_type;

   typedef struct packed {
      home_step_type step;
      arm_cmd_type   arm;
      usb_cmd_type   usb;
      sw_cmd_type    sw;
      clk_cmd_type   clk;
      logic          done;
   } home_out_type;

   // One pass of the homing machine. A command field of NONE means no command.
   function automatic home_out_type home_eval(home_step_type step, status_type stat);
      home_out_type r;
      r.step = step;
      r.arm  = ARM_NONE;
      r.usb  = USB_NONE;
      r.sw   = SW_NONE;
      r.clk  = CLK_NONE;
      r.done = 1'b0;
      case (step)
         HOME_IDLE: begin
         end
         HOME_SWITCH_OFF: begin
            if (stat.sw_on) begin
               r.sw  = SW_OFF;
               r.clk = CLK_STOP;
            end else begin
               r.step = HOME_UNPLUG;
            end
         end
         HOME_UNPLUG: begin
            if (stat.plugged) begin
               r.usb = USB_DISCONNECT;
            end else if (stat.unplugged) begin
               r.step = HOME_RELEASE;
            end
         end
         HOME_RELEASE: begin
            if (stat.caught) begin
               r.arm = ARM_RELEASE;
            end else if (stat.released) begin
               r.step = HOME_DONE;
            end
         end
         default: begin
            r.step = HOME_IDLE;
            r.done = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

@@ sv/dcs_if.sv @@
// Channel interfaces of the dock charge sequencer: the tick request channel
// and the result channel. Depends on dcs_pkg.
interface dcs_req_if import dcs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] catch_count;
   logic [7:0] ms_elapsed;
   logic       arm_released;
   logic       arm_caught;
   logic       usb_plugged;
   logic       usb_unplugged;
   logic       switch_on;

   modport source (
      output valid, req_type, catch_count, ms_elapsed, arm_released, arm_caught,
             usb_plugged, usb_unplugged, switch_on,
      input  ready
   );
   modport sink (
      input  valid, req_type, catch_count, ms_elapsed, arm_released, arm_caught,
             usb_plugged, usb_unplugged, switch_on,
      output ready
   );
endinterface

interface dcs_rsp_if import dcs_pkg::*; ();
   logic        valid;
   logic        ready;
   arm_cmd_type arm_cmd;
   usb_cmd_type usb_cmd;
   sw_cmd_type  switch_cmd;
   clk_cmd_type charge_clock_cmd;
   logic        start_done;
   logic        stop_done;
   logic        power_on_done;
   logic        power_on_finished;
   logic        charging_now;
   logic        at_home;

   modport source (
      output valid, arm_cmd, usb_cmd, switch_cmd, charge_clock_cmd, start_done,
             stop_done, power_on_done, power_on_finished, charging_now, at_home,
      input  ready
   );
   modport sink (
      input  valid, arm_cmd, usb_cmd, switch_cmd, charge_clock_cmd, start_done,
             stop_done, power_on_done, power_on_finished, charging_now, at_home,
      output ready
   );
endinterface

@@ sv/dock_charge_sequencer.sv @@
// Top level of the dock charge sequencer: input register, step machines and
// result register. Depends on dcs_pkg and the channel interfaces in dcs_if.sv.
//
// Each accepted tick is captured in an input register, evaluated combinationally
// by the start, stop, power-on, homing and charging step machines, and its
// result is written to a result register; one tick can be accepted in every
// cycle while the result is not stalled. The input register moves forward
// whenever the result register is empty or being taken, so a stalled result
// holds at most one further tick inside.
// Configuration writes take effect on the next clock edge.
module dock_charge_sequencer import dcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dcs_req_if.sink     req_chan,
   dcs_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [7:0]  default_catch_ff;
   logic [15:0] power_hold_ff;

   logic        s1_valid_ff;
   logic [2:0]  s1_req_ff;
   logic [7:0]  s1_count_ff;
   logic [7:0]  s1_ms_ff;
   status_type  s1_stat_ff;

   home_step_type   home_ff, home_in;
   charge_step_type charge_ff, charge_in;
   start_step_type  start_ff, start_in;
   stop_step_type   stop_ff, stop_in;
   power_step_type  power_ff, power_in;
   logic [7:0]      catches_ff, catches_in;
   logic            retried_ff, retried_in;
   logic [7:0]      target_ff, target_in;
   logic [15:0]     hold_ff, hold_in;
   logic            finished_ff, finished_in;

   arm_cmd_type arm_c;
   usb_cmd_type usb_c;
   sw_cmd_type  sw_c;
   clk_cmd_type clk_c;
   logic        start_done_c, stop_done_c, power_done_c;

   logic        rsp_valid_ff;
   arm_cmd_type rsp_arm_ff, rsp_arm_in;
   usb_cmd_type rsp_usb_ff, rsp_usb_in;
   sw_cmd_type  rsp_sw_ff, rsp_sw_in;
   clk_cmd_type rsp_clk_ff, rsp_clk_in;
   logic [5:0]  rsp_flags_ff, rsp_flags_in;

   logic s1_advance;

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_catch_ff <= DEFAULT_CATCH_RESET;
         power_hold_ff    <= POWER_HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEFAULT_CATCH: default_catch_ff <= csr_wdata[7:0];
            CSR_POWER_HOLD:    power_hold_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_req_ff            <= req_chan.req_type;
         s1_count_ff          <= req_chan.catch_count;
         s1_ms_ff             <= req_chan.ms_elapsed;
         s1_stat_ff.released  <= req_chan.arm_released;
         s1_stat_ff.caught    <= req_chan.arm_caught;
         s1_stat_ff.plugged   <= req_chan.usb_plugged;
         s1_stat_ff.unplugged <= req_chan.usb_unplugged;
         s1_stat_ff.sw_on     <= req_chan.switch_on;
      end
   end

   // The machines run in a fixed order within one tick; later machines see
   // the steps that earlier ones left, and the last command issued wins.
   always_comb begin
      home_out_type ho_a;
      home_out_type ho_b;
      logic [16:0]  hold_sum;
      logic         charge_done;

      home_in      = home_ff;
      charge_in    = charge_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      power_in     = power_ff;
      catches_in   = catches_ff;
      retried_in   = retried_ff;
      target_in    = target_ff;
      hold_in      = hold_ff;
      finished_in  = finished_ff;
      arm_c        = ARM_NONE;
      usb_c        = USB_NONE;
      sw_c         = SW_NONE;
      clk_c        = CLK_NONE;
      start_done_c = 1'b0;
      stop_done_c  = 1'b0;
      power_done_c = 1'b0;
      charge_done  = 1'b0;
      ho_a         = '0;
      ho_b         = '0;
      hold_sum     = '0;

      case (req_code_type'(s1_req_ff))
         REQ_START_DEFAULT: begin
            start_in  = START_BEGIN;
            target_in = default_catch_ff;
         end
         REQ_START_COUNT: begin
            start_in  = START_BEGIN;
            target_in = s1_count_ff;
         end
         REQ_STOP: begin
            stop_in = STOP_BEGIN;
         end
         REQ_POWER_ON: begin
            power_in    = POWER_BEGIN;
            finished_in = 1'b0;
         end
         default: begin
         end
      endcase

      case (start_in)
         START_IDLE: begin
         end
         START_BEGIN: begin
            home_in  = HOME_SWITCH_OFF;
            start_in = START_HOMING;
         end
         START_HOMING: begin
            ho_a    = home_eval(home_in, s1_stat_ff);
            home_in = ho_a.step;
            if (ho_a.arm != ARM_NONE) arm_c = ho_a.arm;
            if (ho_a.usb != USB_NONE) usb_c = ho_a.usb;
            if (ho_a.sw != SW_NONE) sw_c = ho_a.sw;
            if (ho_a.clk != CLK_NONE) clk_c = ho_a.clk;
            if (ho_a.done) begin
               charge_in = CHARGE_INIT;
               start_in  = START_CHARGING;
            end
         end
         START_CHARGING: begin
            case (charge_in)
               CHARGE_IDLE: begin
               end
               CHARGE_INIT, CHARGE_CATCH: begin
                  if (charge_in == CHARGE_INIT) begin
                     catches_in = '0;
                     retried_in = 1'b0;
                     charge_in  = CHARGE_CATCH;
                  end
                  if (s1_stat_ff.released) begin
                     arm_c = ({1'b0, target_in} <= ({1'b0, catches_in} + 9'd1)) ?
                             ARM_HOLD : ARM_ONCE;
                     catches_in = catches_in + 8'd1;
                  end else if (s1_stat_ff.caught) begin
                     if (catches_in >= target_in) begin
                        charge_in = CHARGE_PLUG;
                     end else begin
                        arm_c = ARM_RELEASE;
                     end
                  end
               end
               CHARGE_PLUG: begin
                  if (s1_stat_ff.unplugged) begin
                     usb_c = USB_CONNECT;
                  end else if (s1_stat_ff.plugged) begin
                     if (!retried_in) begin
                        catches_in = '0;
                        charge_in  = CHARGE_REPLUG;
                        retried_in = 1'b1;
                     end else begin
                        charge_in = CHARGE_SWITCH_ON;
                     end
                  end
               end
               CHARGE_SWITCH_ON: begin
                  if (!s1_stat_ff.sw_on) begin
                     sw_c  = SW_ON;
                     clk_c = CLK_START;
                  end else begin
                     charge_in = CHARGE_COMPLETE;
                  end
               end
               CHARGE_REPLUG: begin
                  if (s1_stat_ff.plugged) begin
                     usb_c = USB_DISCONNECT;
                  end else if (s1_stat_ff.unplugged) begin
                     charge_in = CHARGE_CATCH;
                  end
               end
               default: begin
                  charge_in   = CHARGE_IDLE;
                  charge_done = 1'b1;
               end
            endcase
            if (charge_done) start_in = START_DONE;
         end
         default: begin
            start_in     = START_IDLE;
            start_done_c = 1'b1;
         end
      endcase

      case (stop_in)
         STOP_IDLE: begin
         end
         STOP_BEGIN: begin
            home_in = HOME_SWITCH_OFF;
            stop_in = STOP_HOMING;
         end
         STOP_HOMING: begin
            ho_b    = home_eval(home_in, s1_stat_ff);
            home_in = ho_b.step;
            if (ho_b.arm != ARM_NONE) arm_c = ho_b.arm;
            if (ho_b.usb != USB_NONE) usb_c = ho_b.usb;
            if (ho_b.sw != SW_NONE) sw_c = ho_b.sw;
            if (ho_b.clk != CLK_NONE) clk_c = ho_b.clk;
            if (ho_b.done) stop_in = STOP_DONE;
         end
         default: begin
            stop_in     = STOP_IDLE;
            stop_done_c = 1'b1;
         end
      endcase

      case (power_in)
         POWER_IDLE: begin
         end
         POWER_BEGIN: begin
            start_in  = START_BEGIN;
            target_in = POWER_CATCH_COUNT;
            power_in  = POWER_WAIT_START;
         end
         POWER_WAIT_START: begin
            if (start_in == START_IDLE) begin
               hold_in  = '0;
               power_in = POWER_HOLD;
            end
         end
         POWER_HOLD: begin
            hold_sum = {1'b0, hold_in} + {9'd0, s1_ms_ff};
            hold_in  = hold_sum[16] ? HOLD_TIMER_MAX : hold_sum[15:0];
            if (hold_in >= power_hold_ff) begin
               stop_in  = STOP_BEGIN;
               power_in = POWER_WAIT_STOP;
            end
         end
         POWER_WAIT_STOP: begin
            if (stop_in == STOP_IDLE) power_in = POWER_DONE;
         end
         default: begin
            power_in     = POWER_IDLE;
            power_done_c = 1'b1;
         end
      endcase

      if (power_done_c) finished_in = 1'b1;
   end

   always_comb begin
      rsp_arm_in   = arm_c;
      rsp_usb_in   = usb_c;
      rsp_sw_in    = sw_c;
      rsp_clk_in   = clk_c;
      rsp_flags_in = {start_done_c, stop_done_c, power_done_c, finished_in,
                      s1_stat_ff.caught && s1_stat_ff.plugged && s1_stat_ff.sw_on,
                      s1_stat_ff.released && s1_stat_ff.unplugged && !s1_stat_ff.sw_on};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff     <= HOME_IDLE;
         charge_ff   <= CHARGE_IDLE;
         start_ff    <= START_IDLE;
         stop_ff     <= STOP_IDLE;
         power_ff    <= POWER_IDLE;
         catches_ff  <= '0;
         retried_ff  <= 1'b0;
         target_ff   <= CATCH_TARGET_RESET;
         hold_ff     <= '0;
         finished_ff <= 1'b0;
      end else if (s1_advance) begin
         home_ff     <= home_in;
         charge_ff   <= charge_in;
         start_ff    <= start_in;
         stop_ff     <= stop_in;
         power_ff    <= power_in;
         catches_ff  <= catches_in;
         retried_ff  <= retried_in;
         target_ff   <= target_in;
         hold_ff     <= hold_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_arm_ff   <= rsp_arm_in;
         rsp_usb_ff   <= rsp_usb_in;
         rsp_sw_ff    <= rsp_sw_in;
         rsp_clk_ff   <= rsp_clk_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.arm_cmd           = rsp_arm_ff;
   assign rsp_chan.usb_cmd           = rsp_usb_ff;
   assign rsp_chan.switch_cmd        = rsp_sw_ff;
   assign rsp_chan.charge_clock_cmd  = rsp_clk_ff;
   assign rsp_chan.start_done        = rsp_flags_ff[5];
   assign rsp_chan.stop_done         = rsp_flags_ff[4];
   assign rsp_chan.power_on_done     = rsp_flags_ff[3];
   assign rsp_chan.power_on_finished = rsp_flags_ff[2];
   assign rsp_chan.charging_now      = rsp_flags_ff[1];
   assign rsp_chan.at_home           = rsp_flags_ff[0];

endmodule
